[rtl/core/color_saturation_boost_rgb565_macros.svh]
// Assertion helpers used by the checker of this block.
`ifndef COLOR_SATURATION_BOOST_RGB565_MACROS_SVH
`define COLOR_SATURATION_BOOST_RGB565_MACROS_SVH

// Plain clocked assertion, off while reset is held.
`define CSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A stalled signal keeps its value into the next cycle.
`define CSB_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
    `CSB_ASSERT(label, clk, rst_n, (vld && !rdy) |=> $stable(sig), msg)

`endif

[rtl/core/csb_pkg.sv]
package csb_pkg;

    localparam int RGB_W  = 24;
    localparam int PIX_W  = 16;
    localparam int CH_W   = 8;
    localparam int N_CH   = 3;
    localparam int D10_W  = 12;
    localparam int PROD_W = 16;
    localparam int NUM_W  = 21;
    localparam int DEN_W  = 13;

    // saturation blend: (7*c*d + 13*(c-mn)*mx) / (20*d)
    localparam int SAT_KC  = 7;
    localparam int SAT_KS  = 13;
    localparam int SAT_DEN = 20;
    localparam int GREY_K  = 10;

    // brightness lift window and target
    localparam int BRI_LO  = 32;
    localparam int BRI_HI  = 220;
    localparam int BRI_TGT = 220;

    // divider: quotient bits resolved per stage
    localparam int QBITS   = 2;
    localparam int DIV_STG = CH_W / QBITS;

    // pipeline register indexes
    localparam int ST_IN    = 0;
    localparam int ST_MAX   = 1;
    localparam int ST_DIFF  = 2;
    localparam int ST_MUL   = 3;
    localparam int ST_NUM   = 4;
    localparam int ST_SDIV0 = 5;
    localparam int ST_SEL   = ST_SDIV0 + DIV_STG;
    localparam int ST_BDIV0 = ST_SEL + 1;
    localparam int ST_OUT   = ST_BDIV0 + DIV_STG;
    localparam int N_STG    = ST_OUT + 1;

    typedef struct packed {
        logic                               pres;
        logic [N_CH-1:0][CH_W-1:0]          ch;
        logic [N_CH-1:0][CH_W-1:0]          cs;
        logic [CH_W-1:0]                    mx;
        logic [CH_W-1:0]                    mn;
        logic [CH_W-1:0]                    d;
        logic                               sat_en;
        logic                               bri_en;
        logic [N_CH-1:0][PROD_W-1:0]        p1;
        logic [N_CH-1:0][PROD_W-1:0]        p2;
        logic [N_CH-1:0][NUM_W-1:0]         rem;
        logic [DEN_W-1:0]                   den;
        logic [N_CH-1:0][CH_W-1:0]          q;
        logic [PIX_W-1:0]                   pix;
    } t_stage;

endpackage

[rtl/core/color_saturation_boost_rgb565.sv]
// Request path: IN, MAX, DIFF, MUL, NUM, SDIV, SEL, BDIV, OUT stage registers.
// Throughput without stalls: one request per cycle; each of 15 stages holds one item.
// Two restoring dividers (saturation, brightness) resolve 2 quotient bits per stage.
// Backpressure: each stage moves when it is empty or its successor moves.
// Reset: synchronous, active low; clears the stage valid bits only.
module color_saturation_boost_rgb565 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [csb_pkg::RGB_W-1:0] i_s_axis_tdata,  // [23:0] color_rgb
    input  logic                      i_s_axis_tuser,  // [0] color_present
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [csb_pkg::PIX_W-1:0] o_m_axis_tdata   // [15:0] pixel_565
);

    csb_pkg::t_stage                  r_st [csb_pkg::N_STG];
    csb_pkg::t_stage                  n_st [csb_pkg::N_STG];
    logic [csb_pkg::N_STG-1:0]        r_vld;
    logic [csb_pkg::N_STG:0]          en;

    function automatic csb_pkg::t_stage div_step(csb_pkg::t_stage s, int j);
        csb_pkg::t_stage                o;
        int                             pos;
        logic [csb_pkg::NUM_W-1:0]      dsh;
        o = s;
        for (int i = 0; i < csb_pkg::N_CH; i++) begin
            for (int t = 0; t < csb_pkg::QBITS; t++) begin
                pos = csb_pkg::CH_W - 1 - csb_pkg::QBITS * j - t;
                dsh = csb_pkg::NUM_W'(s.den) << pos;
                if (o.rem[i] >= dsh) begin
                    o.rem[i] = o.rem[i] - dsh;
                    o.q[i]   = o.q[i] | (csb_pkg::CH_W'(1) << pos);
                end
            end
        end
        return o;
    endfunction

    // stage enables, from the output back to the input
    always_comb begin
        en[csb_pkg::N_STG] = i_m_axis_tready;
        for (int k = csb_pkg::N_STG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        csb_pkg::t_stage c;

        // capture
        c      = '0;
        c.pres = i_s_axis_tuser;
        c.ch   = i_s_axis_tdata;
        n_st[csb_pkg::ST_IN] = c;

        // largest / smallest channel
        c    = r_st[csb_pkg::ST_IN];
        c.mx = c.ch[0];
        c.mn = c.ch[0];
        for (int i = 1; i < csb_pkg::N_CH; i++) begin
            if (c.ch[i] > c.mx) c.mx = c.ch[i];
            if (c.ch[i] < c.mn) c.mn = c.ch[i];
        end
        n_st[csb_pkg::ST_MAX] = c;

        // d > floor(mx/10) is the same as 10*d > mx for integers
        c        = r_st[csb_pkg::ST_MAX];
        c.d      = c.mx - c.mn;
        c.sat_en = (csb_pkg::D10_W'(c.d) * csb_pkg::D10_W'(csb_pkg::GREY_K))
                   > csb_pkg::D10_W'(c.mx);
        c.bri_en = (c.mx >= csb_pkg::CH_W'(csb_pkg::BRI_LO))
                   && (c.mx < csb_pkg::CH_W'(csb_pkg::BRI_HI));
        n_st[csb_pkg::ST_DIFF] = c;

        c = r_st[csb_pkg::ST_DIFF];
        for (int i = 0; i < csb_pkg::N_CH; i++) begin
            c.p1[i] = csb_pkg::PROD_W'(c.ch[i]) * csb_pkg::PROD_W'(c.d);
            c.p2[i] = csb_pkg::PROD_W'(c.ch[i] - c.mn) * csb_pkg::PROD_W'(c.mx);
        end
        n_st[csb_pkg::ST_MUL] = c;

        c = r_st[csb_pkg::ST_MUL];
        for (int i = 0; i < csb_pkg::N_CH; i++) begin
            c.rem[i] = csb_pkg::NUM_W'(c.p1[i]) * csb_pkg::NUM_W'(csb_pkg::SAT_KC)
                     + csb_pkg::NUM_W'(c.p2[i]) * csb_pkg::NUM_W'(csb_pkg::SAT_KS);
        end
        c.den = csb_pkg::DEN_W'(c.d) * csb_pkg::DEN_W'(csb_pkg::SAT_DEN);
        c.q   = '0;
        n_st[csb_pkg::ST_NUM] = c;

        for (int j = 0; j < csb_pkg::DIV_STG; j++) begin
            n_st[csb_pkg::ST_SDIV0 + j] = div_step(r_st[csb_pkg::ST_SDIV0 + j - 1], j);
        end

        // pick boosted or raw channel, set up c*220/mx
        c = r_st[csb_pkg::ST_SEL - 1];
        for (int i = 0; i < csb_pkg::N_CH; i++) begin
            c.cs[i]  = c.sat_en ? c.q[i] : c.ch[i];
            c.rem[i] = csb_pkg::NUM_W'(c.cs[i]) * csb_pkg::NUM_W'(csb_pkg::BRI_TGT);
        end
        c.den = csb_pkg::DEN_W'(c.mx);
        c.q   = '0;
        n_st[csb_pkg::ST_SEL] = c;

        for (int j = 0; j < csb_pkg::DIV_STG; j++) begin
            n_st[csb_pkg::ST_BDIV0 + j] = div_step(r_st[csb_pkg::ST_BDIV0 + j - 1], j);
        end

        // pack 5-6-5
        c = r_st[csb_pkg::ST_OUT - 1];
        for (int i = 0; i < csb_pkg::N_CH; i++) begin
            if (c.bri_en) c.cs[i] = c.q[i];
        end
        c.pix = c.pres ? {c.cs[2][7:3], c.cs[1][7:2], c.cs[0][7:3]} : '0;
        n_st[csb_pkg::ST_OUT] = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < csb_pkg::N_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < csb_pkg::N_STG; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[csb_pkg::N_STG-1];
    assign o_m_axis_tdata  = r_st[csb_pkg::ST_OUT].pix;

endmodule

[rtl/core/csb_checker.sv]
`include "color_saturation_boost_rgb565_macros.svh"

module csb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic [csb_pkg::RGB_W-1:0] i_s_axis_tdata,  // [23:0] color_rgb
    input logic                      i_s_axis_tuser,  // [0] color_present
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [csb_pkg::PIX_W-1:0] o_m_axis_tdata   // [15:0] pixel_565
);

    // a free output slot frees every stage, so the input must be open
    `CSB_ASSERT(a_ready_space, i_clk, i_rst_n, (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready, "input blocked with room in pipeline")

    `CSB_ASSERT(a_rst_empty, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_m_axis_tvalid, "result shown right after reset")

    `CSB_ASSERT(a_vld_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid, "result dropped while stalled")

    `CSB_ASSERT_HOLD(a_data_hold, i_clk, i_rst_n, o_m_axis_tvalid, i_m_axis_tready, o_m_axis_tdata, "result changed while stalled")

endmodule

bind color_saturation_boost_rgb565 csb_checker u_csb_checker (.*);

[verif/tb_color_saturation_boost_rgb565.sv]
module tb_color_saturation_boost_rgb565;

    localparam int RGB_W       = csb_pkg::RGB_W;
    localparam int PIX_W       = csb_pkg::PIX_W;

    localparam int N_RANDOM    = 1800;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_WAIT  = 40;

    // saturation blend 0.35*c + 0.65*stretched, as exact integer ratios
    localparam int KEEP_W    = 7;
    localparam int STRETCH_W = 13;
    localparam int BLEND_DEN = 20;
    localparam int GREY_DIV  = 10;
    localparam int LIFT_LO   = 32;
    localparam int LIFT_HI   = 220;
    localparam int LIFT_TGT  = 220;

    typedef struct {
        logic [RGB_W-1:0] rgb;
        logic             pres;
        logic [PIX_W-1:0] pixel;
    } t_pixel_exp;

    class pixel_scoreboard;
        t_pixel_exp expected_pixels[$];
        int         n_colors;
        int         n_absent;
        int         n_saturated;
        int         n_lifted;
        int         n_pixels;
        int         n_errors;

        function logic [PIX_W-1:0] boost_pixel(logic [RGB_W-1:0] rgb, logic pres);
            logic [31:0] ch[3];
            logic [31:0] mx;
            logic [31:0] mn;
            logic [31:0] d;
            if (!pres) begin
                return '0;
            end
            ch[0] = 32'(rgb[23:16]);
            ch[1] = 32'(rgb[15:8]);
            ch[2] = 32'(rgb[7:0]);
            mx = ch[0];
            mn = ch[0];
            for (int i = 1; i < 3; i++) begin
                if (ch[i] > mx) mx = ch[i];
                if (ch[i] < mn) mn = ch[i];
            end
            d = mx - mn;
            if (mx > 0 && d > 0 && d > mx / GREY_DIV) begin
                n_saturated++;
                for (int i = 0; i < 3; i++) begin
                    ch[i] = (KEEP_W * ch[i] * d + STRETCH_W * (ch[i] - mn) * mx)
                            / (BLEND_DEN * d);
                end
            end
            // lift uses mx from before the blend
            if (mx >= LIFT_LO && mx < LIFT_HI) begin
                n_lifted++;
                for (int i = 0; i < 3; i++) begin
                    ch[i] = (ch[i] * LIFT_TGT) / mx;
                end
            end
            return {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
        endfunction

        function void note_color(logic [RGB_W-1:0] rgb, logic pres);
            t_pixel_exp e;
            e.rgb   = rgb;
            e.pres  = pres;
            e.pixel = boost_pixel(rgb, pres);
            n_colors++;
            if (!pres) n_absent++;
            expected_pixels.push_back(e);
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pixel);
            t_pixel_exp e;
            n_pixels++;
            if (expected_pixels.size() == 0) begin
                n_errors++;
                $error("pixel_565: unexpected result %h with no request pending", pixel);
                return;
            end
            e = expected_pixels.pop_front();
            if (pixel !== e.pixel) begin
                n_errors++;
                $error("pixel_565 mismatch (color %h present %b): expected %h, actual %h",
                       e.rgb, e.pres, e.pixel, pixel);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [RGB_W-1:0] i_s_axis_tdata;   // [23:0] color_rgb
    logic             i_s_axis_tuser;   // [0] color_present
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [PIX_W-1:0] o_m_axis_tdata;   // [15:0] pixel_565

    pixel_scoreboard sb = new();
    int              n_cycles;
    int              src_quiet;

    color_saturation_boost_rgb565 u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_color(i_s_axis_tdata, i_s_axis_tuser);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_pixel(o_m_axis_tdata);
            end
        end
    end

    // output side backpressure, with quiet stretches of no stalls
    initial begin
        int stall_left;
        int quiet_left;
        int r;
        stall_left = 0;
        quiet_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_left > 0) begin
                quiet_left--;
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    quiet_left = $urandom_range(50, 300);
                end else if (r < 28) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    task automatic send_color(input logic [RGB_W-1:0] rgb, input logic pres);
        int gap;
        gap = 0;
        if (src_quiet > 0) begin
            src_quiet--;
        end else if ($urandom_range(0, 99) < 2) begin
            src_quiet = $urandom_range(30, 200);
        end else if ($urandom_range(0, 99) >= 55) begin
            gap = gap_len();
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rgb;
        i_s_axis_tuser  <= pres;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        logic [24:0]      directed[$];
        logic [7:0]       ch[3];
        logic [RGB_W-1:0] rgb;
        logic             pres;
        int               kind;
        int               mx;
        int               spread;
        int               k;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        n_cycles        = 0;
        src_quiet       = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // {present, color}
        directed = '{
            {1'b0, 24'hFFFFFF}, {1'b0, 24'h123456}, {1'b1, 24'h000000},
            {1'b1, 24'hFFFFFF}, {1'b1, 24'hFF0000}, {1'b1, 24'h00FF00},
            {1'b1, 24'h0000FF}, {1'b1, 24'h808080},
            {1'b1, 24'hC8B4B4},   // spread equals mx/10: no blend
            {1'b1, 24'hC8B3B3},   // one above: blended
            {1'b1, 24'h1F0000}, {1'b1, 24'h200000}, {1'b1, 24'h20100A},
            {1'b1, 24'hDB1020}, {1'b1, 24'hDC1020}, {1'b1, 24'hFF8000},
            {1'b1, 24'h0A0B0C}, {1'b1, 24'h010000}, {1'b1, 24'h7F3FBF},
            {1'b1, 24'h5A5A5A}, {1'b1, 24'hA5A5A5}, {1'b1, 24'h20201F},
            {1'b1, 24'hDBDBDB}
        };
        foreach (directed[i]) begin
            send_color(directed[i][23:0], directed[i][24]);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            pres = 1'b1;
            if (kind < 25) begin
                rgb = RGB_W'($urandom());
            end else if (kind < 33) begin
                rgb  = RGB_W'($urandom());
                pres = 1'b0;
            end else begin
                if (kind < 55) begin
                    mx = $urandom_range(0, 255);
                    spread = mx / GREY_DIV + 1;    // hug the grey threshold
                end else if (kind < 70) begin
                    case ($urandom_range(0, 5))
                        0: mx = 31;
                        1: mx = 32;
                        2: mx = 219;
                        3: mx = 220;
                        4: mx = 255;
                        default: mx = $urandom_range(1, 8);
                    endcase
                    spread = mx;
                end else begin
                    mx = $urandom_range(16, 240);
                    spread = mx;
                end
                for (int i = 0; i < 3; i++) begin
                    ch[i] = 8'($urandom_range(mx, (mx > spread) ? mx - spread : 0));
                end
                k = $urandom_range(0, 2);
                ch[k] = 8'(mx);
                rgb = {ch[0], ch[1], ch[2]};
            end
            send_color(rgb, pres);
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d pixels from %0d colors (%0d absent)",
                 sb.n_pixels, sb.n_colors, sb.n_absent);
        $display("saturation blend hit %0d times, brightness lift %0d times, %0d errors",
                 sb.n_saturated, sb.n_lifted, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[color_saturation_boost_rgb565.f]
+incdir+rtl/core
rtl/core/csb_pkg.sv
rtl/core/color_saturation_boost_rgb565.sv
rtl/core/csb_checker.sv
verif/tb_color_saturation_boost_rgb565.sv
